### rtl/dps_pkg.sv
package dps_pkg;

    localparam int DPS_QUEUE_DEPTH = 8;

    localparam int TAG_W  = 8;
    localparam int SVC_W  = 16;
    localparam int PRIO_W = 16;
    localparam int TICK_W = 32;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    localparam logic signed [PRIO_W-1:0] PRIO_MIN = {1'b1, {(PRIO_W-1){1'b0}}};

    typedef struct packed {
        logic        [TAG_W-1:0]  tag;
        logic        [SVC_W-1:0]  svc;
        logic signed [PRIO_W-1:0] prio;
    } t_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HEAD,
        ST_PREP,
        ST_WALK
    } t_state;

endpackage

### rtl/dps_ram.sv
module dps_ram #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  dps_pkg::t_entry   i_wr_data,
    input  logic [AW-1:0]     i_rd_addr,
    output dps_pkg::t_entry   o_rd_data
);
    import dps_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/dynamic_priority_scheduler_core.sv
// Channel  Handshake                  Payload
// input    i_in_valid / o_in_ready    i_action, i_task_id, i_service_time, i_start_priority
// output   o_out_valid / i_out_ready  o_ran_id, o_time_left, o_new_priority, o_finished,
//                                     o_idle, o_ticks_run
//
// The queue lives in a circular buffer in one RAM with a registered read port.
// A load goes through ST_PREP and, while entries shift, ST_WALK. A tick reads the head
// in ST_HEAD, waiting there for the output register, and requeues the task through
// ST_PREP and ST_WALK unless it finishes. The ordered insert shifts entries back from
// the tail one entry a cycle, at most QUEUE_DEPTH - 1 of them. A dropped load or a
// tick on an empty queue is handled in ST_IDLE itself.
// Reset clears the queue length and tick count; the RAM itself is not cleared.
// The output register holds a result while the next item is taken if the queue is non-empty.
module dynamic_priority_scheduler_core #(
    parameter int QUEUE_DEPTH = dps_pkg::DPS_QUEUE_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_action,
    input  logic [dps_pkg::TAG_W-1:0]           i_task_id,
    input  logic [dps_pkg::SVC_W-1:0]           i_service_time,
    input  logic signed [dps_pkg::PRIO_W-1:0]   i_start_priority,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [dps_pkg::TAG_W-1:0]           o_ran_id,
    output logic [dps_pkg::SVC_W-1:0]           o_time_left,
    output logic signed [dps_pkg::PRIO_W-1:0]   o_new_priority,
    output logic                                o_finished,
    output logic                                o_idle,
    output logic [dps_pkg::TICK_W-1:0]          o_ticks_run
);
    import dps_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LW = $clog2(QUEUE_DEPTH + 1);

    t_state r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [LW-1:0] r_len, n_len;
    logic [AW-1:0] r_k, n_k;
    t_entry r_new, n_new;
    logic [TICK_W-1:0] r_ticks, n_ticks;

    logic r_out_valid, n_out_valid;
    logic [TAG_W-1:0] r_ran_id, n_ran_id;
    logic [SVC_W-1:0] r_time_left, n_time_left;
    logic signed [PRIO_W-1:0] r_new_prio, n_new_prio;
    logic r_finished, n_finished;
    logic r_idle, n_idle;
    logic [TICK_W-1:0] r_ticks_run, n_ticks_run;

    logic wr_en;
    logic [AW-1:0] wr_addr;
    t_entry wr_data;
    logic [AW-1:0] rd_addr;
    t_entry rd_data;

    logic out_free;
    logic in_xfer;
    logic [SVC_W-1:0] head_svc;
    logic signed [PRIO_W-1:0] head_prio;
    logic head_done;

    // Logical queue position to RAM address, wrapping around the buffer.
    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] head,
                                             input logic [AW-1:0] off);
        logic [AW:0] s;
        s = {1'b0, head} + {1'b0, off};
        if (s >= (AW+1)'(QUEUE_DEPTH)) begin
            s = s - (AW+1)'(QUEUE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    dps_ram #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && ((r_len != '0) || out_free);
    assign in_xfer    = i_in_valid && o_in_ready;

    assign head_svc  = (rd_data.svc != '0) ? rd_data.svc - SVC_W'(1) : rd_data.svc;
    assign head_prio = (rd_data.prio != PRIO_MIN) ? rd_data.prio - PRIO_W'(1) : rd_data.prio;
    assign head_done = (head_svc == '0);

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_len       = r_len;
        n_k         = r_k;
        n_new       = r_new;
        n_ticks     = r_ticks;
        n_out_valid = r_out_valid && !i_out_ready;
        n_ran_id    = r_ran_id;
        n_time_left = r_time_left;
        n_new_prio  = r_new_prio;
        n_finished  = r_finished;
        n_idle      = r_idle;
        n_ticks_run = r_ticks_run;
        wr_en       = 1'b0;
        wr_addr     = f_phys(r_head, r_k);
        wr_data     = r_new;
        rd_addr     = f_phys(r_head, '0);

        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (i_action == ACT_TICK) begin
                        if (r_len == '0) begin
                            n_out_valid = 1'b1;
                            n_ran_id    = '0;
                            n_time_left = '0;
                            n_new_prio  = '0;
                            n_finished  = 1'b0;
                            n_idle      = 1'b1;
                            n_ticks_run = r_ticks;
                        end else begin
                            n_state = ST_HEAD;
                        end
                    end else if ((i_service_time != '0) && (r_len != LW'(QUEUE_DEPTH))) begin
                        n_new.tag  = i_task_id;
                        n_new.svc  = i_service_time;
                        n_new.prio = i_start_priority;
                        n_k        = r_len[AW-1:0];
                        n_state    = ST_PREP;
                    end
                end
            end
            ST_HEAD: begin
                // The head entry sits on the read port; hold here until the
                // output register can take the result.
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_ran_id    = rd_data.tag;
                    n_time_left = head_svc;
                    n_new_prio  = head_prio;
                    n_finished  = head_done;
                    n_idle      = 1'b0;
                    n_ticks     = (r_ticks != '1) ? r_ticks + TICK_W'(1) : r_ticks;
                    n_ticks_run = n_ticks;
                    n_head      = f_phys(r_head, AW'(1));
                    n_len       = r_len - LW'(1);
                    if (head_done) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_new.tag  = rd_data.tag;
                        n_new.svc  = head_svc;
                        n_new.prio = head_prio;
                        n_k        = n_len[AW-1:0];
                        n_state    = ST_PREP;
                    end
                end
            end
            ST_PREP: begin
                rd_addr = f_phys(r_head, r_k - AW'(1));
                if (r_k == '0) begin
                    wr_en   = 1'b1;
                    n_len   = r_len + LW'(1);
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                // rd_data holds the entry just ahead of slot r_k. Shift it back
                // while it has lower priority, prefetching the next one.
                rd_addr = f_phys(r_head, r_k - AW'(2));
                wr_en   = 1'b1;
                if (rd_data.prio >= r_new.prio) begin
                    n_len   = r_len + LW'(1);
                    n_state = ST_IDLE;
                end else begin
                    wr_data = rd_data;
                    n_k     = r_k - AW'(1);
                    if (r_k == AW'(1)) begin
                        n_state = ST_PREP;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_len       <= '0;
            r_ticks     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_len       <= n_len;
            r_ticks     <= n_ticks;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k         <= n_k;
        r_new       <= n_new;
        r_ran_id    <= n_ran_id;
        r_time_left <= n_time_left;
        r_new_prio  <= n_new_prio;
        r_finished  <= n_finished;
        r_idle      <= n_idle;
        r_ticks_run <= n_ticks_run;
    end

    assign o_out_valid    = r_out_valid;
    assign o_ran_id       = r_ran_id;
    assign o_time_left    = r_time_left;
    assign o_new_priority = r_new_prio;
    assign o_finished     = r_finished;
    assign o_idle         = r_idle;
    assign o_ticks_run    = r_ticks_run;

endmodule
